// ----- rtl/double_ended_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Double-ended priority queue assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depq checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define DEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depq checker: next-cycle property failed");

`endif

// ----- rtl/depq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Widths, command codes and the control group handed to the cell chains.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int COUNT_OUT_W  = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MAX = 2'd1,
        CMD_DEL_MIN = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic ins;
        logic pop_head;
        logic drop_tail;
        logic clear;
    } t_cell_ctrl;

endpackage

// ----- rtl/double_ended_priority_queue.sv -----
`timescale 1ns / 1ps
// Latency: a result appears in the output register in the cycle after its request is taken.
// One request per cycle while o_stall is low; all cells compare the broadcast key at once.
// Both sorted chains shift by at most one slot per request, so no request waits on another.
// Reset (synchronous, active low) empties the queue by clearing the count and cell valid bits.
// No clearing pass runs; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Two sorted cell chains hold the same entries, one ascending and one
// descending, so the smallest and largest entries both sit at a fixed head.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [depq_pkg::CMD_W-1:0]              i_command,
    input  logic signed [depq_pkg::VALUE_W-1:0]     i_value,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [depq_pkg::VALUE_W-1:0]     o_largest,
    output logic signed [depq_pkg::VALUE_W-1:0]     o_smallest,
    output logic                                    o_is_empty,
    output logic [depq_pkg::COUNT_OUT_W-1:0]        o_entry_count,
    output logic                                    o_rejected
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                                w_accept;
    logic                                w_full;
    logic                                w_empty;
    depq_pkg::t_cell_ctrl                w_asc_ctrl;
    depq_pkg::t_cell_ctrl                w_desc_ctrl;
    logic signed [depq_pkg::VALUE_W-1:0] w_min_head;
    logic signed [depq_pkg::VALUE_W-1:0] w_max_head;
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    logic                                r_out_vld;
    logic                                r_rejected;
    logic                                n_rejected;

    assign o_stall  = r_out_vld && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Removing the smallest shifts the ascending chain and trims the tail of
    // the descending one; removing the largest is the mirror image.
    always_comb begin
        w_asc_ctrl  = '0;
        w_desc_ctrl = '0;
        n_count     = r_count;
        n_rejected  = 1'b0;
        if (w_accept) begin
            case (depq_pkg::t_cmd'(i_command))
                depq_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_rejected = 1'b1;
                    end else begin
                        w_asc_ctrl.ins  = 1'b1;
                        w_desc_ctrl.ins = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                end
                depq_pkg::CMD_DEL_MAX: begin
                    if (!w_empty) begin
                        w_asc_ctrl.drop_tail = 1'b1;
                        w_desc_ctrl.pop_head = 1'b1;
                        n_count              = r_count - 1'b1;
                    end
                end
                depq_pkg::CMD_DEL_MIN: begin
                    if (!w_empty) begin
                        w_asc_ctrl.pop_head   = 1'b1;
                        w_desc_ctrl.drop_tail = 1'b1;
                        n_count               = r_count - 1'b1;
                    end
                end
                depq_pkg::CMD_CLEAR: begin
                    w_asc_ctrl.clear  = 1'b1;
                    w_desc_ctrl.clear = 1'b1;
                    n_count           = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    depq_chain #(
        .CAPACITY(CAPACITY),
        .DESCEND (1'b0)
    ) u_asc_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_asc_ctrl),
        .i_key   (i_value),
        .o_head  (w_min_head)
    );

    depq_chain #(
        .CAPACITY(CAPACITY),
        .DESCEND (1'b1)
    ) u_desc_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_desc_ctrl),
        .i_key   (i_value),
        .o_head  (w_max_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rejected <= n_rejected;
        end
    end

    // The chain heads and the count only move when a request is taken, so
    // they hold steady while a result waits.
    assign o_valid       = r_out_vld;
    assign o_largest     = w_empty ? '0 : w_max_head;
    assign o_smallest    = w_empty ? '0 : w_min_head;
    assign o_is_empty    = w_empty;
    assign o_entry_count = depq_pkg::COUNT_OUT_W'(r_count);
    assign o_rejected    = r_rejected;

endmodule

// ----- rtl/depq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended priority queue cell
// One slot of a sorted chain: holds a value and a valid bit, and on each
// request keeps, takes the new key, takes a neighbour's slot, or empties.
// ----------------------------------------------------------------------------
module depq_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  depq_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [depq_pkg::VALUE_W-1:0] i_key,
    input  logic                                i_left_le,
    input  logic signed [depq_pkg::VALUE_W-1:0] i_left_val,
    input  logic                                i_left_vld,
    input  logic signed [depq_pkg::VALUE_W-1:0] i_right_val,
    input  logic                                i_right_vld,
    output logic                                o_le,
    output logic signed [depq_pkg::VALUE_W-1:0] o_val,
    output logic                                o_vld
);

    logic signed [depq_pkg::VALUE_W-1:0] r_val;
    logic signed [depq_pkg::VALUE_W-1:0] n_val;
    logic                                r_vld;
    logic                                n_vld;
    logic                                w_le;

    // The slot stays put on insert when it sorts ahead of or ties with the new key.
    assign w_le = r_vld && (DESCEND ? (r_val >= i_key) : (r_val <= i_key));

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctrl.clear) begin
            n_vld = 1'b0;
        end else if (i_ctrl.ins) begin
            if (!w_le) begin
                if (i_left_le) begin
                    n_val = i_key;
                    n_vld = 1'b1;
                end else begin
                    n_val = i_left_val;
                    n_vld = i_left_vld;
                end
            end
        end else if (i_ctrl.pop_head) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctrl.drop_tail) begin
            if (r_vld && !i_right_vld) begin
                n_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_le  = w_le;
    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

// ----- rtl/depq_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended priority queue cell chain
// A row of cells kept sorted, ascending or descending, with the head at
// cell zero.
// ----------------------------------------------------------------------------
module depq_chain #(
    parameter int CAPACITY = depq_pkg::CAPACITY_DEF,
    parameter bit DESCEND  = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  depq_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [depq_pkg::VALUE_W-1:0] i_key,
    output logic signed [depq_pkg::VALUE_W-1:0] o_head
);

    logic signed [depq_pkg::VALUE_W-1:0] w_val [CAPACITY];
    logic                                w_vld [CAPACITY];
    logic                                w_le  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                                w_left_le;
        logic signed [depq_pkg::VALUE_W-1:0] w_left_val;
        logic                                w_left_vld;
        logic signed [depq_pkg::VALUE_W-1:0] w_right_val;
        logic                                w_right_vld;

        if (g == 0) begin : g_first
            // Nothing sorts ahead of the first cell, so when it moves on insert it takes the key.
            assign w_left_le  = 1'b1;
            assign w_left_val = '0;
            assign w_left_vld = 1'b0;
        end else begin : g_mid_left
            assign w_left_le  = w_le[g-1];
            assign w_left_val = w_val[g-1];
            assign w_left_vld = w_vld[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_val = '0;
            assign w_right_vld = 1'b0;
        end else begin : g_mid_right
            assign w_right_val = w_val[g+1];
            assign w_right_vld = w_vld[g+1];
        end

        depq_cell #(
            .DESCEND(DESCEND)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_key       (i_key),
            .i_left_le   (w_left_le),
            .i_left_val  (w_left_val),
            .i_left_vld  (w_left_vld),
            .i_right_val (w_right_val),
            .i_right_vld (w_right_vld),
            .o_le        (w_le[g]),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g])
        );
    end

    assign o_head = w_val[0];

endmodule

// ----- rtl/depq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended priority queue checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_macros.svh"

module depq_checker #(
    parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [depq_pkg::VALUE_W-1:0] o_largest,
    input logic signed [depq_pkg::VALUE_W-1:0] o_smallest,
    input logic                                o_is_empty,
    input logic [depq_pkg::COUNT_OUT_W-1:0]    o_entry_count,
    input logic                                o_rejected
);

    logic                                                w_all_zero;
    logic                                                w_full_count;
    logic [2*depq_pkg::VALUE_W+depq_pkg::COUNT_OUT_W-1:0] w_result;

    assign w_all_zero   = (o_largest == '0) && (o_smallest == '0) && (o_entry_count == '0);
    assign w_full_count = (o_entry_count == depq_pkg::COUNT_OUT_W'(CAPACITY));
    assign w_result     = {o_largest, o_smallest, o_entry_count};

    // An empty queue reports zero at both ends and a zero count.
    `DEPQ_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_valid && o_is_empty, w_all_zero)

    // A non-empty queue never reports its smallest above its largest.
    `DEPQ_ASSERT_SAME(a_order, i_clk, i_rst_n, o_valid && !o_is_empty, o_smallest <= o_largest)

    // A refused insert only happens with the store full.
    `DEPQ_ASSERT_SAME(a_reject_full, i_clk, i_rst_n, o_valid && o_rejected, w_full_count)

    // Every request taken yields a result in the next cycle.
    `DEPQ_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_valid && !o_stall, o_valid)

    // A stalled result holds its contents.
    `DEPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(w_result))

endmodule

bind double_ended_priority_queue depq_checker #(
    .CAPACITY(CAPACITY)
) u_depq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_largest     (o_largest),
    .o_smallest    (o_smallest),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count),
    .o_rejected    (o_rejected)
);
